// ----- hdl/ppd_pkg.sv -----
// ----------------------------------------------------------------------------
// ppd_pkg: shared definitions for the pump pulse train driver
// Widths, constants, register indexes and the off-time status bundle.
// ----------------------------------------------------------------------------
package ppd_pkg;

  // Number of pump outputs on the result beat.
  localparam int PUMPS = 4;

  // Defaults for the top-level parameters.
  localparam int CHANNELS_DEF    = 4;
  localparam int PULSE_LIMIT_DEF = 500;

  // Field widths.
  localparam int FLOW_W  = 16;
  localparam int AMB_W   = 12;
  localparam int DRIVE_W = 10;
  localparam int CAL_W   = 24;
  localparam int CNT_W   = 17;
  localparam int PULSE_W = 9;
  localparam int OFF_W   = 18;
  localparam int QUO_W   = 18;
  localparam int NUM_W   = 35;
  localparam int DEN_W   = CAL_W + FLOW_W;
  localparam int DSH_W   = DEN_W + QUO_W - 1;

  // Configuration register indexes.
  localparam logic [2:0] REG_CAL_MODE         = 3'd0;
  localparam logic [2:0] REG_CAL_BURNER       = 3'd1;
  localparam logic [2:0] REG_CAL_TANK         = 3'd2;
  localparam logic [2:0] REG_CAL_PROC_METHANOL = 3'd3;
  localparam logic [2:0] REG_CAL_PROC_WATER   = 3'd4;

  // Operating constants.
  localparam logic [DRIVE_W-1:0] DRIVE_ON   = 10'd700;
  localparam logic [CNT_W-1:0]   COUNT_MAX  = 17'd131071;
  localparam logic [OFF_W-1:0]   OFF_MAX    = 18'd131066;
  localparam logic [CAL_W-1:0]   CAL_RESET  = 24'd273000;
  // 100 ticks per second scaled by 2^28 (Q0.24 calibration times Q12.4 flow).
  localparam logic [NUM_W-1:0]   OFF_NUM    = 35'd26843545600;
  localparam logic signed [AMB_W-1:0] COLD_TENTHS = 12'sd150;
  localparam logic [FLOW_W-1:0]  FLOW_ONE   = 16'd16;
  localparam logic [FLOW_W-1:0]  CAL_FLOW_MIN = 16'd160;
  localparam logic [2:0]         ON_WARM    = 3'd3;
  localparam logic [2:0]         ON_COLD    = 3'd5;

  // Status from the off-time unit back to the sequencer.
  typedef struct packed {
    logic                    done;
    logic signed [OFF_W-1:0] off;
  } ppd_off_t;

endpackage

// ----- hdl/ppd_if.sv -----
// ----------------------------------------------------------------------------
// ppd_in_if / ppd_out_if: valid-ready channels of the pump driver
// One beat in carries the four flow requests and the ambient temperature;
// one beat out carries the four pump drive levels.
// ----------------------------------------------------------------------------
interface ppd_in_if;
  logic                              valid;
  logic                              ready;
  logic [ppd_pkg::FLOW_W-1:0]        flow_burner;
  logic [ppd_pkg::FLOW_W-1:0]        flow_tank;
  logic [ppd_pkg::FLOW_W-1:0]        flow_proc_methanol;
  logic [ppd_pkg::FLOW_W-1:0]        flow_proc_water;
  logic signed [ppd_pkg::AMB_W-1:0]  ambient_tenths;

  modport source (output valid, flow_burner, flow_tank, flow_proc_methanol,
                  flow_proc_water, ambient_tenths, input ready);
  modport sink   (input valid, flow_burner, flow_tank, flow_proc_methanol,
                  flow_proc_water, ambient_tenths, output ready);
endinterface

interface ppd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ppd_pkg::DRIVE_W-1:0] drive_burner;
  logic [ppd_pkg::DRIVE_W-1:0] drive_tank;
  logic [ppd_pkg::DRIVE_W-1:0] drive_proc_methanol;
  logic [ppd_pkg::DRIVE_W-1:0] drive_proc_water;

  modport source (output valid, drive_burner, drive_tank, drive_proc_methanol,
                  drive_proc_water, input ready);
  modport sink   (input valid, drive_burner, drive_tank, drive_proc_methanol,
                  drive_proc_water, output ready);
endinterface

// ----- hdl/ppd_off.sv -----
// ----------------------------------------------------------------------------
// ppd_off: off-time unit
// Multiplies calibration by flow, then runs a restoring divider one quotient
// bit per cycle and turns the quotient into a saturated off time, truncated unless below three.
// ----------------------------------------------------------------------------
module ppd_off (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ppd_pkg::CAL_W-1:0]    cal,
  input  logic [ppd_pkg::FLOW_W-1:0]   flow,
  output ppd_pkg::ppd_off_t            stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                         st_r, st_nxt;
  logic                               done_r;
  logic [ppd_pkg::CAL_W-1:0]          cal_r;
  logic [ppd_pkg::FLOW_W-1:0]         flow_r;
  logic [ppd_pkg::DSH_W-1:0]          dsh_r;
  logic [ppd_pkg::NUM_W-1:0]          rem_r;
  logic [ppd_pkg::QUO_W-1:0]          q_r;
  logic [4:0]                         step_r;
  logic signed [ppd_pkg::OFF_W-1:0]   off_r;

  logic [ppd_pkg::DEN_W-1:0]          prod;
  logic                               fit;
  logic [ppd_pkg::QUO_W-1:0]          q_m3;
  logic [ppd_pkg::QUO_W-1:0]          q_ceil;
  logic signed [ppd_pkg::OFF_W-1:0]   fin_off;

  // Product of calibration and flow; one 24 by 16 multiply.
  assign prod = {16'd0, cal_r} * {24'd0, flow_r};

  // Trial subtraction of the shifted divisor.
  assign fit = {{(ppd_pkg::DSH_W - ppd_pkg::NUM_W){1'b0}}, rem_r} >= dsh_r;

  // Quotient to off time: floor minus three when the quotient is three or
  // more, ceiling minus three below that, saturated at the top. A zero
  // divisor leaves every quotient bit set, which saturates as well.
  always_comb begin
    q_m3   = q_r - 18'd3;
    q_ceil = q_r + {17'd0, (rem_r != '0)};
    if (q_r[ppd_pkg::QUO_W-1]) begin
      fin_off = signed'(ppd_pkg::OFF_MAX);
    end else if (q_r >= 18'd3) begin
      fin_off = (q_m3 > ppd_pkg::OFF_MAX) ? signed'(ppd_pkg::OFF_MAX) : signed'(q_m3);
    end else begin
      fin_off = signed'(q_ceil) - 18'sd3;
    end
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (start) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_DIV;
      S_DIV:  if (step_r == 5'd0) st_nxt = S_FIN;
      S_FIN:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == S_FIN);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        cal_r  <= cal;
        flow_r <= flow;
      end
      S_MUL: begin
        dsh_r  <= {prod, {(ppd_pkg::QUO_W-1){1'b0}}};
        rem_r  <= ppd_pkg::OFF_NUM;
        q_r    <= '0;
        step_r <= 5'(ppd_pkg::QUO_W - 1);
      end
      S_DIV: begin
        if (fit) begin
          rem_r <= rem_r - dsh_r[ppd_pkg::NUM_W-1:0];
        end
        q_r    <= {q_r[ppd_pkg::QUO_W-2:0], fit};
        dsh_r  <= dsh_r >> 1;
        step_r <= step_r - 5'd1;
      end
      S_FIN: begin
        off_r <= fin_off;
      end
      default: begin
      end
    endcase
  end

  assign stat.done = done_r;
  assign stat.off  = off_r;

endmodule

// ----- hdl/pump_pulse_train_driver.sv -----
// ----------------------------------------------------------------------------
// pump_pulse_train_driver: four-pump stroke timing per 10 ms tick
// Steps: per pump a load and an update, with a wait on the divider between
//   for each pump whose off time is divided out (normal mode, flow of at
//   least 1), then a done step. One beat per sweep; the divider in ppd_off
//   runs one quotient bit per cycle, 18 bits per pump. A new beat is taken
//   while a finished result still waits at the output.
// Reset: synchronous active-low; counters clear, calibration takes defaults.
// ----------------------------------------------------------------------------
module pump_pulse_train_driver #(
  parameter int CHANNELS    = ppd_pkg::CHANNELS_DEF,
  parameter int PULSE_LIMIT = ppd_pkg::PULSE_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ppd_in_if.sink                    in_bus,
  ppd_out_if.source                 out_bus,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [ppd_pkg::CAL_W-1:0] cfg_data
);

  localparam logic [3:0] CH_ACTIVE = 4'(CHANNELS);
  localparam logic [ppd_pkg::PULSE_W-1:0] LIMIT = ppd_pkg::PULSE_W'(PULSE_LIMIT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                         state_r, state_nxt;
  logic [1:0]                         ch_r;
  logic                               cal_mode_r;
  logic [ppd_pkg::CAL_W-1:0]          cal_r     [ppd_pkg::PUMPS];
  logic [ppd_pkg::CNT_W-1:0]          tick_r    [ppd_pkg::PUMPS];
  logic [ppd_pkg::PULSE_W-1:0]        pd_r      [ppd_pkg::PUMPS];
  logic [ppd_pkg::FLOW_W-1:0]         flow_r    [ppd_pkg::PUMPS];
  logic                               cold_r;
  logic [ppd_pkg::PUMPS-1:0]          drv_r;
  logic [ppd_pkg::PUMPS-1:0]          out_drv_r;
  logic                               out_valid_r;

  ppd_pkg::ppd_off_t                  off_stat;
  logic                               div_start;

  logic [ppd_pkg::CNT_W-1:0]          cnt;
  logic [ppd_pkg::CNT_W-1:0]          cnt_b;
  logic [ppd_pkg::PULSE_W-1:0]        pd;
  logic [ppd_pkg::FLOW_W-1:0]         fl;
  logic                               active;
  logic                               need_div;
  logic signed [ppd_pkg::OFF_W:0]     off_x;
  logic signed [ppd_pkg::OFF_W:0]     lim_x;
  logic signed [ppd_pkg::OFF_W:0]     cnt_s;
  logic signed [ppd_pkg::OFF_W:0]     cntb_s;
  logic [ppd_pkg::CNT_W-1:0]          offc;
  logic [ppd_pkg::CNT_W-1:0]          limc;
  logic [ppd_pkg::CNT_W-1:0]          tick_nxt;
  logic [ppd_pkg::PULSE_W-1:0]        pd_nxt;
  logic                               on_nxt;
  logic                               out_free;

  // Off-time unit shared by all pumps.
  ppd_off u_off (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .cal   (cal_r[ch_r]),
    .flow  (flow_r[ch_r]),
    .stat  (off_stat)
  );

  // Per-pump view of the current channel.
  assign cnt      = tick_r[ch_r];
  assign pd       = pd_r[ch_r];
  assign fl       = flow_r[ch_r];
  assign active   = {2'b00, ch_r} < CH_ACTIVE;
  assign need_div = active && !cal_mode_r && (fl >= ppd_pkg::FLOW_ONE);
  assign cnt_b    = (cnt == ppd_pkg::COUNT_MAX) ? cnt : cnt + 17'd1;
  assign div_start = (state_r == S_LOAD) && need_div;
  assign out_free = !out_valid_r || out_bus.ready;

  // Channel update: drive decision, counter advance and period wrap.
  always_comb begin
    off_x    = {off_stat.off[ppd_pkg::OFF_W-1], off_stat.off};
    lim_x    = off_x + (cold_r ? 19'sd5 : 19'sd3);
    cnt_s    = signed'({2'b00, cnt});
    cntb_s   = signed'({2'b00, cnt_b});
    offc     = {5'd0, fl[15:4]} - 17'd3;
    limc     = {5'd0, fl[15:4]};
    tick_nxt = cnt;
    pd_nxt   = pd;
    on_nxt   = 1'b0;
    if (!active) begin
      on_nxt = 1'b0;
    end else if (cal_mode_r) begin
      if (fl > ppd_pkg::CAL_FLOW_MIN) begin
        on_nxt   = (cnt >= offc) && (pd < LIMIT);
        tick_nxt = cnt_b;
        if (cnt_b >= limc) begin
          tick_nxt = '0;
          if (pd < LIMIT) begin
            pd_nxt = pd + 9'd1;
          end
        end
      end else begin
        pd_nxt = '0;
      end
      if (pd_nxt >= LIMIT) begin
        on_nxt = 1'b0;
      end
    end else if (fl >= ppd_pkg::FLOW_ONE) begin
      on_nxt   = !(cnt_s < off_x);
      tick_nxt = (cntb_s >= lim_x) ? '0 : cnt_b;
    end
  end

  // Sequencer over the four pumps.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_bus.valid) state_nxt = S_LOAD;
      S_LOAD: state_nxt = need_div ? S_WAIT : S_UPD;
      S_WAIT: if (off_stat.done) state_nxt = S_UPD;
      S_UPD:  state_nxt = (ch_r == 2'(ppd_pkg::PUMPS - 1)) ? S_DONE : S_LOAD;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_bus.ready = (state_r == S_IDLE);

  // Control registers and per-pump state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      cal_mode_r  <= 1'b0;
      for (int i = 0; i < ppd_pkg::PUMPS; i++) begin
        cal_r[i]  <= ppd_pkg::CAL_RESET;
        tick_r[i] <= '0;
        pd_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) begin
        ch_r <= '0;
      end else if (state_r == S_UPD) begin
        ch_r         <= ch_r + 2'd1;
        tick_r[ch_r] <= tick_nxt;
        pd_r[ch_r]   <= pd_nxt;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      // Register writes.
      if (cfg_we) begin
        unique case (cfg_index)
          ppd_pkg::REG_CAL_MODE:          cal_mode_r <= cfg_data[0];
          ppd_pkg::REG_CAL_BURNER:        cal_r[0]   <= cfg_data;
          ppd_pkg::REG_CAL_TANK:          cal_r[1]   <= cfg_data;
          ppd_pkg::REG_CAL_PROC_METHANOL: cal_r[2]   <= cfg_data;
          ppd_pkg::REG_CAL_PROC_WATER:    cal_r[3]   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Beat payload capture, per-pump drive bits and the output register.
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      flow_r[0] <= in_bus.flow_burner;
      flow_r[1] <= in_bus.flow_tank;
      flow_r[2] <= in_bus.flow_proc_methanol;
      flow_r[3] <= in_bus.flow_proc_water;
      cold_r    <= (in_bus.ambient_tenths <= ppd_pkg::COLD_TENTHS);
    end
    if (state_r == S_UPD) begin
      drv_r[ch_r] <= on_nxt;
    end
    if (state_r == S_DONE && out_free) begin
      out_drv_r <= drv_r;
    end
  end

  assign out_bus.valid               = out_valid_r;
  assign out_bus.drive_burner        = out_drv_r[0] ? ppd_pkg::DRIVE_ON : '0;
  assign out_bus.drive_tank          = out_drv_r[1] ? ppd_pkg::DRIVE_ON : '0;
  assign out_bus.drive_proc_methanol = out_drv_r[2] ? ppd_pkg::DRIVE_ON : '0;
  assign out_bus.drive_proc_water    = out_drv_r[3] ? ppd_pkg::DRIVE_ON : '0;

  // The off-time unit only reports while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    off_stat.done |-> (state_r == S_WAIT))
    else $error("off-time result arrived outside the wait state");

  // An accepted beat starts the pump sweep at the first pump.
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> (state_r == S_LOAD && ch_r == 2'd0))
    else $error("accepted beat did not start the sweep");

  // A result only appears at the end of a sweep.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the done state");

  // Pulse counts never pass the limit.
  a_pulse_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (pd_r[0] <= LIMIT) && (pd_r[1] <= LIMIT) && (pd_r[2] <= LIMIT) &&
    (pd_r[3] <= LIMIT))
    else $error("pulse count passed the limit");

endmodule

// ----- tb/sv/ppd_drive_checker.sv -----
// ----------------------------------------------------------------------------
// ppd_drive_checker: scoreboard for the pump pulse train driver
// Watches the flow and drive channels and the register write port, keeps its
// own copy of the per-pump tick counters and calibration settings, predicts
// the four drive levels of every accepted flow beat and compares each drive
// beat with the oldest prediction.
// ----------------------------------------------------------------------------
module ppd_drive_checker #(
  parameter int CHANNELS    = ppd_pkg::CHANNELS_DEF,
  parameter int PULSE_LIMIT = ppd_pkg::PULSE_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ppd_in_if                         in_mon,
  ppd_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [ppd_pkg::CAL_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending_beats
);

  typedef logic [ppd_pkg::PUMPS-1:0][ppd_pkg::DRIVE_W-1:0] drive_set_t;
  typedef logic [ppd_pkg::PUMPS-1:0][ppd_pkg::FLOW_W-1:0]  flow_set_t;

  localparam string PUMP_NAME [ppd_pkg::PUMPS] =
    '{"burner", "tank", "proc_methanol", "proc_water"};

  // Shadow of the block's settings and per-pump state.
  bit                        cal_mode;
  logic [ppd_pkg::CAL_W-1:0] cal_gain [ppd_pkg::PUMPS];
  int                        tick_pos [ppd_pkg::PUMPS];
  int                        pulse_cnt [ppd_pkg::PUMPS];

  drive_set_t drive_expect_q [$];

  // One line per mismatch, and every mismatch is counted.
  task automatic report_mismatch(input string msg);
    $display("%0t: drive mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Off time in ticks: 100 * 2^28 / (gain * flow) - 3, floored (ceiled below three), saturated.
  function automatic int off_ticks(input logic [ppd_pkg::CAL_W-1:0] gain,
                                   input logic [ppd_pkg::FLOW_W-1:0] flow);
    logic [63:0] den;
    logic [63:0] whole;
    den = 64'(gain) * 64'(flow);
    if (den == 64'd0) begin
      return int'(ppd_pkg::OFF_MAX);
    end
    whole = 64'(ppd_pkg::OFF_NUM) / den;
    if (whole >= 64'd3) begin
      return (whole - 64'd3 > 64'(ppd_pkg::OFF_MAX)) ? int'(ppd_pkg::OFF_MAX) :
                                                        int'(whole - 64'd3);
    end
    return int'((64'(ppd_pkg::OFF_NUM) + den - 64'd1) / den) - 3;
  endfunction

  // Advance one pump by one tick and return its drive level.
  function automatic logic [ppd_pkg::DRIVE_W-1:0] pump_step(
    input int ch, input logic [ppd_pkg::FLOW_W-1:0] flow, input bit cold);
    int off;
    int on_len;
    logic [ppd_pkg::DRIVE_W-1:0] lvl;
    lvl = '0;
    if (cal_mode) begin
      if (flow > ppd_pkg::CAL_FLOW_MIN) begin
        off = int'(flow >> 4) - 3;
        if (tick_pos[ch] >= off && pulse_cnt[ch] < PULSE_LIMIT) begin
          lvl = ppd_pkg::DRIVE_ON;
        end
        if (tick_pos[ch] < int'(ppd_pkg::COUNT_MAX)) begin
          tick_pos[ch]++;
        end
        if (tick_pos[ch] >= off + int'(ppd_pkg::ON_WARM)) begin
          tick_pos[ch] = 0;
          if (pulse_cnt[ch] < PULSE_LIMIT) begin
            pulse_cnt[ch]++;
          end
        end
      end else begin
        // A request at or below the threshold restarts the pulse count.
        pulse_cnt[ch] = 0;
      end
      if (pulse_cnt[ch] >= PULSE_LIMIT) begin
        lvl = '0;
      end
      return lvl;
    end
    // Below one mL/h the pump stands still and its counter holds.
    if (flow < ppd_pkg::FLOW_ONE) begin
      return '0;
    end
    off = off_ticks(cal_gain[ch], flow);
    on_len = cold ? int'(ppd_pkg::ON_COLD) : int'(ppd_pkg::ON_WARM);
    lvl = (tick_pos[ch] < off) ? '0 : ppd_pkg::DRIVE_ON;
    if (tick_pos[ch] < int'(ppd_pkg::COUNT_MAX)) begin
      tick_pos[ch]++;
    end
    if (tick_pos[ch] >= off + on_len) begin
      tick_pos[ch] = 0;
    end
    return lvl;
  endfunction

  // Expected drive beat for one flow beat.
  function automatic drive_set_t drive_levels(input flow_set_t flows,
                                              input logic signed [ppd_pkg::AMB_W-1:0] amb);
    drive_set_t lv;
    bit cold;
    cold = (amb <= ppd_pkg::COLD_TENTHS);
    for (int i = 0; i < ppd_pkg::PUMPS; i++) begin
      lv[i] = (i < CHANNELS) ? pump_step(i, flows[i], cold) : '0;
    end
    return lv;
  endfunction

  // Sample every channel at the clock edge.
  always @(posedge clk) begin
    drive_set_t want;
    drive_set_t got;
    if (!rst_n) begin
      cal_mode = 1'b0;
      for (int i = 0; i < ppd_pkg::PUMPS; i++) begin
        cal_gain[i] = ppd_pkg::CAL_RESET;
        tick_pos[i] = 0;
        pulse_cnt[i] = 0;
      end
      drive_expect_q.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          ppd_pkg::REG_CAL_MODE:          cal_mode = cfg_data[0];
          ppd_pkg::REG_CAL_BURNER:        cal_gain[0] = cfg_data;
          ppd_pkg::REG_CAL_TANK:          cal_gain[1] = cfg_data;
          ppd_pkg::REG_CAL_PROC_METHANOL: cal_gain[2] = cfg_data;
          ppd_pkg::REG_CAL_PROC_WATER:    cal_gain[3] = cfg_data;
          default: ;
        endcase
      end
      // Flow beat accepted: predict its drive beat.
      if (in_mon.valid && in_mon.ready) begin
        drive_expect_q.push_back(drive_levels({in_mon.flow_proc_water, in_mon.flow_proc_methanol,
                                               in_mon.flow_tank, in_mon.flow_burner},
                                              in_mon.ambient_tenths));
      end
      // Drive beat accepted: compare with the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.drive_proc_water, out_mon.drive_proc_methanol,
               out_mon.drive_tank, out_mon.drive_burner};
        if (drive_expect_q.size() == 0) begin
          report_mismatch($sformatf("drive beat %h with none expected", got));
        end else begin
          want = drive_expect_q.pop_front();
          for (int i = 0; i < ppd_pkg::PUMPS; i++) begin
            if (got[i] !== want[i]) begin
              report_mismatch($sformatf("%s got %0d expected %0d", PUMP_NAME[i], got[i],
                                        want[i]));
            end
          end
        end
      end
    end
    pending_beats <= drive_expect_q.size();
  end

endmodule

// ----- tb/sv/pump_pulse_train_driver_tb.sv -----
// ----------------------------------------------------------------------------
// pump_pulse_train_driver_tb: regression for the pump pulse train driver
// Drives directed and random flow beats through several calibration settings,
// normal and calibration mode, ending with a calibration stretch without
// idling, with random idling on both channels; the checker predicts and
// compares.
// ----------------------------------------------------------------------------
module pump_pulse_train_driver_tb;

  typedef logic [ppd_pkg::PUMPS-1:0][ppd_pkg::FLOW_W-1:0] flow_set_t;
  typedef logic [ppd_pkg::PUMPS-1:0][ppd_pkg::CAL_W-1:0]  cal_set_t;

  localparam int         CYCLE_LIMIT = 600000;
  localparam int         END_QUIET   = 100;
  localparam int         TAIL_BEATS  = 120;
  localparam int         RESTART_AT  = 60;
  localparam logic [2:0] REG_UNUSED  = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [2:0]                cfg_index;
  logic [ppd_pkg::CAL_W-1:0] cfg_data;
  int                        fail_count;
  int                        pending_beats;
  bit                        idle_on;
  int                        stall_left;

  ppd_in_if  in_bus ();
  ppd_out_if out_bus ();

  pump_pulse_train_driver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ppd_drive_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Drive side backpressure: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Watchdog.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Flow request spread over magnitudes, so that off times range widely.
  function automatic logic [ppd_pkg::FLOW_W-1:0] pick_flow();
    int k;
    logic [ppd_pkg::FLOW_W-1:0] v;
    k = $urandom_range(0, ppd_pkg::FLOW_W);
    if (k == 0) begin
      return '0;
    end
    v = ppd_pkg::FLOW_W'($urandom_range(1 << (k - 1), (1 << k) - 1));
    return v;
  endfunction

  function automatic logic [ppd_pkg::CAL_W-1:0] pick_cal();
    int k;
    logic [ppd_pkg::CAL_W-1:0] v;
    k = $urandom_range(0, ppd_pkg::CAL_W);
    if (k == 0) begin
      return '0;
    end
    v = ppd_pkg::CAL_W'($urandom_range(1 << (k - 1), (1 << k) - 1));
    return v;
  endfunction

  // Flow for calibration mode: mostly short periods above the threshold.
  function automatic logic [ppd_pkg::FLOW_W-1:0] pick_cal_flow();
    int r;
    logic [ppd_pkg::FLOW_W-1:0] v;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      v = ppd_pkg::FLOW_W'($urandom_range(0, ppd_pkg::CAL_FLOW_MIN));
    end else if (r == 2) begin
      v = pick_flow();
    end else begin
      v = ppd_pkg::FLOW_W'($urandom_range(ppd_pkg::CAL_FLOW_MIN + 1,
                                          ppd_pkg::CAL_FLOW_MIN + 16 * 24));
    end
    return v;
  endfunction

  // Ambient mostly in the rated range, sometimes any 12-bit value.
  function automatic logic signed [ppd_pkg::AMB_W-1:0] pick_ambient();
    logic signed [ppd_pkg::AMB_W-1:0] a;
    if ($urandom_range(0, 9) == 0) begin
      a = ppd_pkg::AMB_W'($urandom);
    end else begin
      a = ppd_pkg::AMB_W'($urandom_range(0, 1650) - 400);
    end
    return a;
  endfunction

  // Present one flow beat and hold it until it is taken.
  task automatic send_beat(input flow_set_t flows,
                           input logic signed [ppd_pkg::AMB_W-1:0] amb);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_bus.valid              <= 1'b1;
    in_bus.flow_burner        <= flows[0];
    in_bus.flow_tank          <= flows[1];
    in_bus.flow_proc_methanol <= flows[2];
    in_bus.flow_proc_water    <= flows[3];
    in_bus.ambient_tenths     <= amb;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted drive beat has come back.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [ppd_pkg::CAL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write every register; optionally also poke an index that does not exist.
  task automatic write_settings(input bit mode, input cal_set_t gains, input bit poke_unused);
    if (poke_unused) begin
      write_reg(REG_UNUSED, '1);
    end
    write_reg(ppd_pkg::REG_CAL_MODE, ppd_pkg::CAL_W'(mode));
    write_reg(ppd_pkg::REG_CAL_BURNER, gains[0]);
    write_reg(ppd_pkg::REG_CAL_TANK, gains[1]);
    write_reg(ppd_pkg::REG_CAL_PROC_METHANOL, gains[2]);
    write_reg(ppd_pkg::REG_CAL_PROC_WATER, gains[3]);
    cfg_we <= 1'b0;
  endtask

  // Random beats; each pump keeps its request for a random stretch.
  task automatic run_random(input int count, input bit cal_style);
    flow_set_t flows;
    int hold [ppd_pkg::PUMPS];
    flows = '0;
    for (int i = 0; i < ppd_pkg::PUMPS; i++) begin
      hold[i] = 0;
    end
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 59) == 0) begin
        wait_drained();
      end
      for (int i = 0; i < ppd_pkg::PUMPS; i++) begin
        if (hold[i] == 0) begin
          flows[i] = cal_style ? pick_cal_flow() : pick_flow();
          hold[i] = $urandom_range(1, 40);
        end
        hold[i]--;
      end
      send_beat(flows, pick_ambient());
    end
  endtask

  // Stimulus and verdict.
  initial begin
    cal_set_t  gains;
    flow_set_t flows;
    rst_n                     <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_index                 <= ppd_pkg::REG_CAL_MODE;
    cfg_data                  <= '0;
    in_bus.valid              <= 1'b0;
    in_bus.flow_burner        <= '0;
    in_bus.flow_tank          <= '0;
    in_bus.flow_proc_methanol <= '0;
    in_bus.flow_proc_water    <= '0;
    in_bus.ambient_tenths     <= '0;
    idle_on                   = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Default settings: flow and temperature extremes, thresholds, short periods.
    send_beat({16'd0, 16'd0, 16'd0, 16'd0}, 12'sd0);
    send_beat({16'd0, 16'hFFFF, 16'd16, 16'd15}, -12'sd400);
    send_beat({16'd16, 16'd16, 16'd16, 16'd16}, 12'sd150);
    send_beat({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 12'sd151);
    send_beat({16'd32768, 16'd1, 16'd15, 16'd65535}, 12'sd1250);
    send_beat({16'hFFFF, 16'h8000, 16'h7FFF, 16'd0}, 12'sh800);
    send_beat({16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00}, 12'sh7FF);
    for (int n = 0; n < 14; n++) begin
      send_beat({16'd4000, 16'd65535, 16'd20000, 16'd8000}, (n < 7) ? 12'sd200 : -12'sd50);
    end

    // Zero gain, full-scale gain and unit gain.
    wait_drained();
    write_settings(1'b0, {ppd_pkg::CAL_RESET, 24'd1, 24'hFFFFFF, 24'd0}, 1'b1);
    send_beat({16'd16, 16'hFFFF, 16'd16, 16'd16}, 12'sd300);
    send_beat({16'hFFFF, 16'd16, 16'hFFFF, 16'hFFFF}, 12'sd100);
    send_beat({16'd15, 16'd100, 16'd16, 16'd40000}, 12'sd300);
    send_beat({16'd1000, 16'hFFFF, 16'd2000, 16'd1}, -12'sd400);

    // Gains near the default.
    wait_drained();
    for (int i = 0; i < ppd_pkg::PUMPS; i++) begin
      gains[i] = ($urandom_range(0, 1) == 0) ? ppd_pkg::CAL_RESET :
                                                ppd_pkg::CAL_W'($urandom_range(150000, 400000));
    end
    write_settings(1'b0, gains, 1'b0);
    run_random(200, 1'b0);

    // Gains over the whole range.
    wait_drained();
    for (int i = 0; i < ppd_pkg::PUMPS; i++) begin
      gains[i] = pick_cal();
    end
    write_settings(1'b0, gains, 1'b0);
    run_random(200, 1'b0);

    // Calibration mode with mixed requests.
    wait_drained();
    for (int i = 0; i < ppd_pkg::PUMPS; i++) begin
      gains[i] = pick_cal();
    end
    write_settings(1'b1, gains, 1'b0);
    run_random(150, 1'b1);

    // Calibration stretch without idling; the burner drops below the
    // threshold for a few beats to restart its pulse count.
    wait_drained();
    write_settings(1'b1, {24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF}, 1'b0);
    idle_on = 1'b0;
    for (int n = 0; n < TAIL_BEATS + 5; n++) begin
      for (int i = 0; i < ppd_pkg::PUMPS - 1; i++) begin
        flows[i] = ppd_pkg::FLOW_W'($urandom_range(ppd_pkg::CAL_FLOW_MIN + 1,
                                                   ppd_pkg::CAL_FLOW_MIN + 15));
      end
      flows[ppd_pkg::PUMPS-1] = pick_cal_flow();
      if (n >= RESTART_AT && n < RESTART_AT + 5) begin
        flows[0] = ppd_pkg::FLOW_W'($urandom_range(0, ppd_pkg::CAL_FLOW_MIN));
      end
      send_beat(flows, pick_ambient());
    end

    // Let everything come back, then allow stray beats a chance to show.
    wait_drained();
    repeat (END_QUIET) @(posedge clk);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ppd_pkg.sv
hdl/ppd_if.sv
hdl/ppd_off.sv
hdl/pump_pulse_train_driver.sv
tb/sv/ppd_drive_checker.sv
tb/sv/pump_pulse_train_driver_tb.sv
